@@ hdl/braille_cell_to_ansi_text_core_defines.svh @@
// assertion macros for the braille cell to ansi text core
// used by the port checker; no other dependencies
`ifndef BRAILLE_CELL_TO_ANSI_TEXT_CORE_DEFINES_SVH
`define BRAILLE_CELL_TO_ANSI_TEXT_CORE_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BCAT_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcat port check failed");

// consequent checked in the cycle after the antecedent
`define BCAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcat port check failed");

`endif

@@ hdl/bcat_pkg.sv @@
// shared types and constants for the braille cell to ansi text core
// no dependencies; used by the interfaces, top level, controller and datapath
package bcat_pkg;

    // field widths
    localparam int MASK_W     = 8;
    localparam int COLOUR_W   = 24;
    localparam int BYTE_W     = 8;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int POS_W      = 5;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_BASE    = 2'd2
    } t_cfg_idx;

    // byte positions inside one cell's text
    localparam logic [POS_W-1:0] POS_RED_H = 5'd7;
    localparam logic [POS_W-1:0] POS_RED_T = 5'd8;
    localparam logic [POS_W-1:0] POS_RED_O = 5'd9;
    localparam logic [POS_W-1:0] POS_GRN_H = 5'd11;
    localparam logic [POS_W-1:0] POS_GRN_T = 5'd12;
    localparam logic [POS_W-1:0] POS_GRN_O = 5'd13;
    localparam logic [POS_W-1:0] POS_BLU_H = 5'd15;
    localparam logic [POS_W-1:0] POS_BLU_T = 5'd16;
    localparam logic [POS_W-1:0] POS_BLU_O = 5'd17;
    localparam logic [POS_W-1:0] POS_UTF0  = 5'd19;
    localparam logic [POS_W-1:0] POS_UTF1  = 5'd20;
    localparam logic [POS_W-1:0] POS_UTF2  = 5'd21;
    localparam logic [POS_W-1:0] POS_NL    = 5'd22;

    // last step of the bit-serial divider (one quotient bit per step)
    localparam logic [POS_W-1:0] DIV_LAST  = 5'd7;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_DIGIT,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic             capture;
        logic             prepare;
        logic             div_step;
        logic             digits;
        logic             load;
        logic [POS_W-1:0] pos;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic newline;
    } t_stat;

endpackage

@@ hdl/bcat_if.sv @@
// valid/ready channel interfaces: braille cell items in, text byte items out
// depends on bcat_pkg for field widths
interface bcat_cell_if;
    logic                          valid;
    logic                          ready;
    logic [bcat_pkg::MASK_W-1:0]   dot_mask;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row0_left;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row0_right;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row1_left;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row1_right;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row2_left;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row2_right;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row3_left;
    logic [bcat_pkg::COLOUR_W-1:0] colour_row3_right;

    modport source (
        output valid, dot_mask,
        output colour_row0_left, colour_row0_right, colour_row1_left, colour_row1_right,
        output colour_row2_left, colour_row2_right, colour_row3_left, colour_row3_right,
        input  ready
    );
    modport sink (
        input  valid, dot_mask,
        input  colour_row0_left, colour_row0_right, colour_row1_left, colour_row1_right,
        input  colour_row2_left, colour_row2_right, colour_row3_left, colour_row3_right,
        output ready
    );
endinterface

interface bcat_byte_if;
    logic                        valid;
    logic                        ready;
    logic [bcat_pkg::BYTE_W-1:0] out_byte;
    logic                        last_of_cell;

    modport source (output valid, out_byte, last_of_cell, input ready);
    modport sink   (input valid, out_byte, last_of_cell, output ready);
endinterface

@@ hdl/braille_cell_to_ansi_text_core.sv @@
// top level of the braille cell to ansi text core
// depends on bcat_pkg, bcat_if, bcat_ctrl and bcat_datapath
//
// Takes one braille cell per item and sends its text one byte per item: a
// 19-byte truecolour escape with the truncated average colour of the lit
// dots (white when none is lit), the 3-byte UTF-8 character char_base plus
// the mask, and a newline after the last cell of every row but the frame's
// last. A cell is handled in turn: the colours are summed, each channel's
// sum goes through its own lane of the one-bit-per-cycle divider (the
// divisor is shared), the quotients are split into decimal digits, then
// one byte per cycle goes into the output register while that register is
// empty or being drained; back-pressure on the output holds the emission
// only while the output register is full.
// The next cell is taken as soon as its predecessor's final byte sits in
// the output register. The user must write configuration through i_cfg_we,
// i_cfg_idx and i_cfg_data only while the core is idle; it is not enforced.
module braille_cell_to_ansi_text_core #(
    parameter int MAX_CELLS_PER_ROW = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcat_pkg::CFG_W-1:0]     i_cfg_data,
    bcat_cell_if.sink                      i_cell,
    bcat_byte_if.source                    o_text
);
    import bcat_pkg::*;

    t_cmd                w_cmd;
    t_stat               w_stat;
    logic [COLOUR_W-1:0] w_colour [8];

    // colour lanes in input order
    assign w_colour[0] = i_cell.colour_row0_left;
    assign w_colour[1] = i_cell.colour_row0_right;
    assign w_colour[2] = i_cell.colour_row1_left;
    assign w_colour[3] = i_cell.colour_row1_right;
    assign w_colour[4] = i_cell.colour_row2_left;
    assign w_colour[5] = i_cell.colour_row2_right;
    assign w_colour[6] = i_cell.colour_row3_left;
    assign w_colour[7] = i_cell.colour_row3_right;

    bcat_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cell.valid),
        .o_in_ready  (i_cell.ready),
        .i_out_ready (o_text.ready),
        .o_out_valid (o_text.valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    bcat_datapath #(
        .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_dot_mask (i_cell.dot_mask),
        .i_colour   (w_colour),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_byte (o_text.out_byte),
        .o_out_last (o_text.last_of_cell)
    );

endmodule

@@ hdl/bcat_ctrl.sv @@
// controller for the braille cell to ansi text core: sequences capture,
// colour sum, divide, digit split and byte emission; depends on bcat_pkg
module bcat_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    output logic           o_out_valid,
    input  bcat_pkg::t_stat i_stat,
    output bcat_pkg::t_cmd  o_cmd
);
    import bcat_pkg::*;

    t_state           r_state, n_state;
    logic [POS_W-1:0] r_step, n_step;
    logic             r_out_valid, n_out_valid;
    logic             w_load;
    logic             w_last;

    // output register takes a byte when empty or being drained
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || i_out_ready);
    assign w_last = i_stat.newline ? (r_step == POS_NL) : (r_step == POS_UTF2);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_PREP;
            S_PREP:  n_state = S_DIV;
            S_DIV:   if (r_step == DIV_LAST) n_state = S_DIGIT;
            S_DIGIT: n_state = S_EMIT;
            S_EMIT:  if (w_load && w_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // step counter: divider steps, then byte position
    always_comb begin
        n_step = r_step;
        case (r_state)
            S_PREP:  n_step = '0;
            S_DIV:   n_step = r_step + POS_W'(1);
            S_DIGIT: n_step = '0;
            S_EMIT:  if (w_load) n_step = r_step + POS_W'(1);
            default: n_step = r_step;
        endcase
    end

    // output valid flag
    always_comb begin
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    // datapath commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.prepare  = (r_state == S_PREP);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.digits   = (r_state == S_DIGIT);
        o_cmd.load     = w_load;
        o_cmd.pos      = r_step;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

@@ hdl/bcat_datapath.sv @@
// datapath for the braille cell to ansi text core: config registers, position
// counters, colour sums, bit-serial divider, digit split, byte mux; uses bcat_pkg
module bcat_datapath #(
    parameter int MAX_CELLS_PER_ROW = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bcat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bcat_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic [bcat_pkg::MASK_W-1:0]    i_dot_mask,
    input  logic [bcat_pkg::COLOUR_W-1:0]  i_colour [8],
    input  bcat_pkg::t_cmd                 i_cmd,
    output bcat_pkg::t_stat                o_stat,
    output logic [bcat_pkg::BYTE_W-1:0]    o_out_byte,
    output logic                           o_out_last
);
    import bcat_pkg::*;

    localparam int CW      = (MAX_CELLS_PER_ROW > 1) ? $clog2(MAX_CELLS_PER_ROW) : 1;
    localparam int CFG_DIM = 11;
    localparam int XW      = (($clog2(MAX_CELLS_PER_ROW + 1) > CFG_DIM) ?
                              $clog2(MAX_CELLS_PER_ROW + 1) : CFG_DIM) + 1;
    localparam int ROW_W   = 10;
    localparam int RW      = 12;
    localparam int SUM_W   = 11;
    localparam int CNT_W   = 4;
    localparam int CH_W    = 8;

    localparam logic [XW-1:0] COLS_MAX = XW'(MAX_CELLS_PER_ROW);
    localparam logic [RW-1:0] ROWS_MAX = 12'd1024;

    // dot bit of each colour lane
    localparam logic [2:0] DOT_OF_LANE [8] = '{3'd0, 3'd3, 3'd1, 3'd4,
                                                3'd2, 3'd5, 3'd6, 3'd7};

    typedef struct packed {
        logic [3:0] h;
        logic [3:0] t;
        logic [3:0] o;
    } t_digits;

    // split a value below 256 into decimal digits
    function automatic t_digits to_digits(input logic [CH_W-1:0] v);
        t_digits    d;
        logic [6:0] rem;
        logic [14:0] prod;
        logic [6:0] tens_x10;
        logic [6:0] ones;
        if (v >= 8'd200) begin
            d.h = 4'd2;
            rem = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            d.h = 4'd1;
            rem = 7'(v - 8'd100);
        end else begin
            d.h = 4'd0;
            rem = v[6:0];
        end
        // multiply by reciprocal of ten, exact below 100
        prod     = 15'(rem) * 15'd205;
        d.t      = prod[14:11];
        tens_x10 = 7'(d.t) * 7'd10;
        ones     = rem - tens_x10;
        d.o      = ones[3:0];
        return d;
    endfunction

    // fixed characters of the colour escape
    function automatic logic [BYTE_W-1:0] esc_byte(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] b;
        case (pos)
            5'd0:    b = 8'h1B;
            5'd1:    b = 8'h5B;
            5'd2:    b = 8'h33;
            5'd3:    b = 8'h38;
            5'd5:    b = 8'h32;
            5'd18:   b = 8'h6D;
            default: b = 8'h3B;
        endcase
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] ascii(input logic [3:0] d);
        return 8'h30 | {4'h0, d};
    endfunction

    logic [10:0]          r_cfg_cols;
    logic [10:0]          r_cfg_rows;
    logic [15:0]          r_cfg_base;
    logic [CW-1:0]        r_col;
    logic [ROW_W-1:0]     r_row;
    logic [MASK_W-1:0]    r_mask;
    logic [COLOUR_W-1:0]  r_colour [8];
    logic [CNT_W-1:0]     r_rem [3];
    logic [CH_W-1:0]      r_quo [3];
    logic [CNT_W-1:0]     r_div;
    t_digits              r_dig [3];
    logic [15:0]          r_cp;
    logic                 r_newline;
    logic [BYTE_W-1:0]    r_out_byte;
    logic                 r_out_last;

    logic [SUM_W-1:0]     w_sum [3];
    logic [SUM_W-1:0]     w_sum_eff [3];
    logic [CNT_W-1:0]     w_cnt;
    logic [XW-1:0]        w_cols;
    logic [XW-1:0]        w_col_next;
    logic [RW-1:0]        w_rows;
    logic [RW-1:0]        w_row_next;
    logic                 w_last_col;
    logic                 w_last_row;
    logic [BYTE_W-1:0]    w_byte;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cols <= 11'd80;
            r_cfg_rows <= 11'd24;
            r_cfg_base <= 16'd10240;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COLUMNS: r_cfg_cols <= i_cfg_data[10:0];
                CFG_ROWS:    r_cfg_rows <= i_cfg_data[10:0];
                CFG_BASE:    r_cfg_base <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // sum of the lit dots per channel
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c] = '0;
        end
        for (int k = 0; k < 8; k++) begin
            if (r_mask[DOT_OF_LANE[k]]) begin
                w_sum[0] = w_sum[0] + SUM_W'(r_colour[k][23:16]);
                w_sum[1] = w_sum[1] + SUM_W'(r_colour[k][15:8]);
                w_sum[2] = w_sum[2] + SUM_W'(r_colour[k][7:0]);
            end
        end
        w_cnt = CNT_W'($countones(r_mask));
        // no dot lit gives white: 255 divided by one
        for (int c = 0; c < 3; c++) begin
            w_sum_eff[c] = (w_cnt == '0) ? SUM_W'(255) : w_sum[c];
        end
    end

    // effective frame size and position checks
    always_comb begin
        w_cols = XW'(r_cfg_cols);
        if (w_cols == '0) begin
            w_cols = XW'(1);
        end else if (w_cols > COLS_MAX) begin
            w_cols = COLS_MAX;
        end
        w_rows = RW'(r_cfg_rows);
        if (w_rows == '0) begin
            w_rows = RW'(1);
        end else if (w_rows > ROWS_MAX) begin
            w_rows = ROWS_MAX;
        end
        w_col_next = XW'(r_col) + XW'(1);
        w_row_next = RW'(r_row) + RW'(1);
        w_last_col = (w_col_next >= w_cols);
        w_last_row = (w_row_next >= w_rows);
    end

    // position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_newline <= 1'b0;
        end else if (i_cmd.prepare) begin
            r_newline <= w_last_col && !w_last_row;
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : w_row_next[ROW_W-1:0];
            end else begin
                r_col <= w_col_next[CW-1:0];
            end
        end
    end

    // item capture, divider and digit registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mask   <= i_dot_mask;
            r_colour <= i_colour;
        end
        if (i_cmd.prepare) begin
            r_cp  <= r_cfg_base + {8'h00, r_mask};
            r_div <= (w_cnt == '0) ? CNT_W'(1) : w_cnt;
            for (int c = 0; c < 3; c++) begin
                // quotient stays below 256, so the top bits start as remainder
                r_rem[c] <= {1'b0, w_sum_eff[c][10:8]};
                r_quo[c] <= w_sum_eff[c][7:0];
            end
        end
        if (i_cmd.div_step) begin
            for (int c = 0; c < 3; c++) begin
                if ({r_rem[c], r_quo[c][7]} >= {1'b0, r_div}) begin
                    r_rem[c] <= CNT_W'({r_rem[c], r_quo[c][7]} - {1'b0, r_div});
                    r_quo[c] <= {r_quo[c][6:0], 1'b1};
                end else begin
                    r_rem[c] <= {r_rem[c][2:0], r_quo[c][7]};
                    r_quo[c] <= {r_quo[c][6:0], 1'b0};
                end
            end
        end
        if (i_cmd.digits) begin
            for (int c = 0; c < 3; c++) begin
                r_dig[c] <= to_digits(r_quo[c]);
            end
        end
    end

    // byte selection by position
    always_comb begin
        case (i_cmd.pos)
            POS_RED_H: w_byte = ascii(r_dig[0].h);
            POS_RED_T: w_byte = ascii(r_dig[0].t);
            POS_RED_O: w_byte = ascii(r_dig[0].o);
            POS_GRN_H: w_byte = ascii(r_dig[1].h);
            POS_GRN_T: w_byte = ascii(r_dig[1].t);
            POS_GRN_O: w_byte = ascii(r_dig[1].o);
            POS_BLU_H: w_byte = ascii(r_dig[2].h);
            POS_BLU_T: w_byte = ascii(r_dig[2].t);
            POS_BLU_O: w_byte = ascii(r_dig[2].o);
            POS_UTF0:  w_byte = 8'hE0 | {4'h0, r_cp[15:12]};
            POS_UTF1:  w_byte = 8'h80 | {2'b00, r_cp[11:6]};
            POS_UTF2:  w_byte = 8'h80 | {2'b00, r_cp[5:0]};
            POS_NL:    w_byte = 8'h0A;
            default:   w_byte = esc_byte(i_cmd.pos);
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_byte <= w_byte;
            r_out_last <= (i_cmd.pos == POS_NL) || ((i_cmd.pos == POS_UTF2) && !r_newline);
        end
    end

    assign o_stat.newline = r_newline;
    assign o_out_byte     = r_out_byte;
    assign o_out_last     = r_out_last;

endmodule

@@ hdl/bcat_checker.sv @@
// port-level checks for the braille cell to ansi text core, bound to the top
// depends on braille_cell_to_ansi_text_core_defines.svh
`include "braille_cell_to_ansi_text_core_defines.svh"

module bcat_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);
    // a stalled output item stays offered and unchanged
    `BCAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `BCAT_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_byte) && $stable(i_out_last))

    // a cell is worked on alone: busy right after it is taken
    `BCAT_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

    // when idle, only the final byte of the previous cell can still wait
    `BCAT_ASSERT_SAME(a_idle_only_last, i_clk, i_rst_n, i_in_ready && i_out_valid, i_out_last)

endmodule

bind braille_cell_to_ansi_text_core bcat_checker u_bcat_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cell.valid),
    .i_in_ready  (i_cell.ready),
    .i_out_valid (o_text.valid),
    .i_out_ready (o_text.ready),
    .i_out_byte  (o_text.out_byte),
    .i_out_last  (o_text.last_of_cell)
);
